[src/iss_pkg.sv]
// Shared types for the integer set sorter: sequencer states, write-data
// selection codes and the memory control bundle. No dependencies.
package iss_pkg;

   // Width of one element of the set.
   localparam int unsigned DataWidth = 32;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_START,
      ST_FIRST,
      ST_STEP,
      ST_TAIL,
      ST_EMIT_READ,
      ST_SHOW
   } state_type;

   // Source of the data written into the element memory.
   typedef enum logic [1:0] {
      WSEL_REQ,
      WSEL_LOW,
      WSEL_HOLD
   } wsel_type;

   // Control bundle from the sequencer to the element memory.
   typedef struct packed {
      logic     rd_en;
      logic     wr_en;
      wsel_type wr_sel;
   } mem_ctl_type;

endpackage

[src/iss_if.sv]
// Valid/ready channel interfaces for the request and response sides.
// Depends on iss_pkg for the element width.
interface iss_req_if import iss_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [DataWidth-1:0] value;
   logic                        is_last;

   modport source (output valid, output value, output is_last, input ready);
   modport sink (input valid, input value, input is_last, output ready);
endinterface

interface iss_rsp_if import iss_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [DataWidth-1:0] sorted_value;
   logic                        is_final;
   logic                        overflow;

   modport source (output valid, output sorted_value, output is_final, output overflow,
                   input ready);
   modport sink (input valid, input sorted_value, input is_final, input overflow,
                 output ready);
endinterface

[src/iss_cmp_unit.sv]
// Shared compare-and-exchange unit: orders two signed elements.
// Depends on iss_pkg for the element width.
module iss_cmp_unit import iss_pkg::*; (
   input  logic signed [DataWidth-1:0] a,
   input  logic signed [DataWidth-1:0] b,
   output logic                        a_gt_b,
   output logic signed [DataWidth-1:0] low,
   output logic signed [DataWidth-1:0] high
);

   // One signed compare selects the smaller and the larger operand.
   always_comb begin
      a_gt_b = (a > b);
      low    = a_gt_b ? b : a;
      high   = a_gt_b ? a : b;
   end

endmodule

[src/iss_ctrl.sv]
// Sequencer of the integer set sorter: load, bubble passes and emission.
// Depends on iss_pkg; drives the element memory held in the top level.
module iss_ctrl import iss_pkg::*; #(
   parameter int unsigned MAX_ELEMENTS = 16,
   localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1,
   localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_is_last,
   output logic                        req_ready,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic                        rsp_is_final,
   output logic                        rsp_overflow,
   input  logic                        cmp_gt,
   input  logic signed [DataWidth-1:0] cmp_high,
   input  logic signed [DataWidth-1:0] rdata,
   output logic signed [DataWidth-1:0] hold,
   output mem_ctl_type                 mem_ctl,
   output logic [AW-1:0]               rd_addr,
   output logic [AW-1:0]               wr_addr
);

   state_type                   state_ff, state_in;
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic [AW-1:0]               idx_ff, idx_in;
   logic signed [DataWidth-1:0] hold_ff, hold_in;
   logic                        swapped_ff, swapped_in;
   logic                        dropped_ff, dropped_in;
   logic [CW-1:0]               cnt_m1;
   logic [AW-1:0]               last_idx;
   logic                        full;
   logic                        req_acc;
   logic                        rsp_acc;

   assign cnt_m1   = cnt_ff - CW'(1);
   assign last_idx = cnt_m1[AW-1:0];
   assign full     = (cnt_ff == CW'(MAX_ELEMENTS));

   assign req_ready    = (state_ff == ST_LOAD);
   assign req_acc      = req_valid && req_ready;
   assign rsp_valid    = (state_ff == ST_SHOW);
   assign rsp_acc      = rsp_valid && rsp_ready;
   assign rsp_is_final = (idx_ff == last_idx);
   assign rsp_overflow = dropped_ff;
   assign hold         = hold_ff;

   // State and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         cnt_ff     <= '0;
         dropped_ff <= 1'b0;
         swapped_ff <= 1'b0;
         idx_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         dropped_ff <= dropped_in;
         swapped_ff <= swapped_in;
         idx_ff     <= idx_in;
      end
   end

   // The held element of a bubble pass needs no reset.
   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

   // Next state and memory control.
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      idx_in         = idx_ff;
      hold_in        = hold_ff;
      swapped_in     = swapped_ff;
      dropped_in     = dropped_ff;
      mem_ctl.rd_en  = 1'b0;
      mem_ctl.wr_en  = 1'b0;
      mem_ctl.wr_sel = WSEL_REQ;
      rd_addr        = idx_ff;
      wr_addr        = cnt_ff[AW-1:0];
      case (state_ff)
         ST_LOAD: begin
            if (req_acc) begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  mem_ctl.wr_en = 1'b1;
                  cnt_in        = cnt_ff + CW'(1);
               end
               if (req_is_last) begin
                  idx_in = '0;
                  // A single element is already in order.
                  state_in = (cnt_ff == '0) ? ST_EMIT_READ : ST_START;
               end
            end
         end
         ST_START: begin
            mem_ctl.rd_en = 1'b1;
            rd_addr       = '0;
            state_in      = ST_FIRST;
         end
         ST_FIRST: begin
            // The first element of a pass becomes the carried maximum.
            hold_in       = rdata;
            swapped_in    = 1'b0;
            mem_ctl.rd_en = 1'b1;
            rd_addr       = AW'(1);
            idx_in        = AW'(1);
            state_in      = ST_STEP;
         end
         ST_STEP: begin
            // Write the smaller of the pair back one place lower, carry the larger.
            mem_ctl.wr_en  = 1'b1;
            mem_ctl.wr_sel = WSEL_LOW;
            wr_addr        = idx_ff - AW'(1);
            hold_in        = cmp_high;
            swapped_in     = swapped_ff || cmp_gt;
            if (idx_ff == last_idx) begin
               state_in = ST_TAIL;
            end else begin
               mem_ctl.rd_en = 1'b1;
               rd_addr       = idx_ff + AW'(1);
               idx_in        = idx_ff + AW'(1);
            end
         end
         ST_TAIL: begin
            // The pass maximum lands at the top; repeat while anything moved.
            mem_ctl.wr_en  = 1'b1;
            mem_ctl.wr_sel = WSEL_HOLD;
            wr_addr        = last_idx;
            if (swapped_ff) begin
               mem_ctl.rd_en = 1'b1;
               rd_addr       = '0;
               state_in      = ST_FIRST;
            end else begin
               idx_in   = '0;
               state_in = ST_EMIT_READ;
            end
         end
         ST_EMIT_READ: begin
            mem_ctl.rd_en = 1'b1;
            rd_addr       = idx_ff;
            state_in      = ST_SHOW;
         end
         ST_SHOW: begin
            if (rsp_acc) begin
               if (rsp_is_final) begin
                  cnt_in     = '0;
                  dropped_in = 1'b0;
                  state_in   = ST_LOAD;
               end else begin
                  mem_ctl.rd_en = 1'b1;
                  rd_addr       = idx_ff + AW'(1);
                  idx_in        = idx_ff + AW'(1);
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // The emit index never runs past the held elements.
   a_emit_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHOW) |-> (idx_ff <= last_idx))
      else $error("emit index beyond held elements");

   // A response is only shown for a non-empty set.
   a_rsp_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (cnt_ff != '0))
      else $error("response with empty set");

   // The final response empties the set and clears the drop mark.
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_acc && rsp_is_final) |=> ((cnt_ff == '0) && !dropped_ff))
      else $error("set not cleared after final response");

   // A request taken with room left grows the set by one.
   a_load_count: assert property (@(posedge clock) disable iff (reset)
      (req_acc && !full) |=> (cnt_ff == $past(cnt_ff) + CW'(1)))
      else $error("element count did not advance");

endmodule

[src/integer_set_sorter.sv]
// Top level of the integer set sorter: element memory, shared compare unit
// and sequencer. Depends on iss_pkg, iss_if, iss_cmp_unit and iss_ctrl.
//
//   Channel  Dir  Payload                                  Transfer
//   req      in   value[31:0] signed, is_last              valid && ready
//   rsp      out  sorted_value[31:0] signed, is_final,     valid && ready
//                 overflow
//
// Loading takes one cycle per request; ready is low from the closing request
// until the final response is taken. Sorting uses bubble passes through one
// comparator and one memory read and write port, at most n passes (stopping
// after a pass without exchanges), after a start state. Emission reads the
// first element, then gives one response per cycle while rsp.ready is high;
// a stall holds the response. Reset is synchronous and needs no clearing
// pass; a set of one element skips the sort.
module integer_set_sorter import iss_pkg::*; #(
   parameter int unsigned MAX_ELEMENTS = 16
) (
   input  logic          clock,
   input  logic          reset,
   iss_req_if.sink       req,
   iss_rsp_if.source     rsp
);

   localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

   logic signed [DataWidth-1:0] store_mem [MAX_ELEMENTS];
   logic signed [DataWidth-1:0] rdata_ff;
   logic signed [DataWidth-1:0] hold;
   logic signed [DataWidth-1:0] cmp_low;
   logic signed [DataWidth-1:0] cmp_high;
   logic signed [DataWidth-1:0] wr_data;
   logic                        cmp_gt;
   mem_ctl_type                 mem_ctl;
   logic [AW-1:0]               rd_addr;
   logic [AW-1:0]               wr_addr;

   // Carried maximum against the element just read.
   iss_cmp_unit u_cmp (
      .a      (hold),
      .b      (rdata_ff),
      .a_gt_b (cmp_gt),
      .low    (cmp_low),
      .high   (cmp_high)
   );

   iss_ctrl #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req.valid),
      .req_is_last  (req.is_last),
      .req_ready    (req.ready),
      .rsp_ready    (rsp.ready),
      .rsp_valid    (rsp.valid),
      .rsp_is_final (rsp.is_final),
      .rsp_overflow (rsp.overflow),
      .cmp_gt       (cmp_gt),
      .cmp_high     (cmp_high),
      .rdata        (rdata_ff),
      .hold         (hold),
      .mem_ctl      (mem_ctl),
      .rd_addr      (rd_addr),
      .wr_addr      (wr_addr)
   );

   // Write data: an arriving element, the lower of a pair, or the pass maximum.
   always_comb begin
      case (mem_ctl.wr_sel)
         WSEL_REQ:  wr_data = req.value;
         WSEL_LOW:  wr_data = cmp_low;
         WSEL_HOLD: wr_data = hold;
         default:   wr_data = req.value;
      endcase
   end

   // Element memory with one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (mem_ctl.rd_en) begin
         rdata_ff <= store_mem[rd_addr];
      end
   end

   // The read register doubles as the response data register.
   assign rsp.sorted_value = rdata_ff;

endmodule

[tb/tb_integer_set_sorter.sv]
// Self-checking testbench for integer_set_sorter: random and directed integer sets
// go in, and every sorted response is compared with a local prediction.
// Depends on iss_pkg, iss_if and the integer_set_sorter RTL.
module tb_integer_set_sorter;
   import iss_pkg::*;

   localparam int unsigned Capacity = 16;
   localparam int RandomRequestTarget = 350;
   localparam int LongHoldCycles = 300;

   typedef struct {
      logic signed [DataWidth-1:0] value;
      logic                        is_last;
      bit                          drain_first;
   } sort_request_type;

   typedef struct {
      logic signed [DataWidth-1:0] sorted_value;
      logic                        is_final;
      logic                        overflow;
   } sorted_result_type;

   logic clock;
   logic reset;

   iss_req_if req_ch ();
   iss_rsp_if rsp_ch ();

   integer_set_sorter #(.MAX_ELEMENTS(Capacity)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // Requests waiting to be sent and responses waiting to arrive.
   sort_request_type  pending_requests[$];
   sorted_result_type expected_sorted[$];

   // Predicted contents of the element store.
   logic signed [DataWidth-1:0] held_values[Capacity];
   int unsigned held_count;
   bit          held_dropped;

   int requests_total;
   int requests_accepted;
   int sets_closed;
   int sets_overflowed;
   int responses_checked;
   int error_count;

   int  burst_left;
   int  gap_left;
   int  hold_left;
   bit  long_hold_done;
   int  stall_mode;
   int  ready_cycle;

   always #2 clock = ~clock;

   // Fold one accepted request into the predicted store; on the closing request,
   // sort what is held and queue the expected responses.
   task automatic predict_sorted_set(input logic signed [DataWidth-1:0] value,
                                     input logic is_last);
      logic signed [DataWidth-1:0] ordered[Capacity];
      logic signed [DataWidth-1:0] swap_value;
      int unsigned min_index;
      sorted_result_type result;
      if (held_count < Capacity) begin
         held_values[held_count] = value;
         held_count++;
      end else begin
         held_dropped = 1'b1;
      end
      if (!is_last) return;
      // Selection sort over the held entries, smallest first.
      for (int unsigned i = 0; i < held_count; i++) ordered[i] = held_values[i];
      for (int unsigned i = 0; i < held_count; i++) begin
         min_index = i;
         for (int unsigned j = i + 1; j < held_count; j++) begin
            if (ordered[j] < ordered[min_index]) min_index = j;
         end
         swap_value = ordered[i];
         ordered[i] = ordered[min_index];
         ordered[min_index] = swap_value;
      end
      for (int unsigned i = 0; i < held_count; i++) begin
         result.sorted_value = ordered[i];
         result.is_final = (i + 1 == held_count);
         result.overflow = held_dropped;
         expected_sorted.push_back(result);
      end
      sets_closed++;
      if (held_dropped) sets_overflowed++;
      held_count = 0;
      held_dropped = 1'b0;
   endtask

   task automatic queue_request(input logic signed [DataWidth-1:0] value, input logic is_last,
                                input bit drain_first);
      sort_request_type item;
      item.value = value;
      item.is_last = is_last;
      item.drain_first = drain_first;
      pending_requests.push_back(item);
   endtask

   function automatic logic signed [DataWidth-1:0] random_element(input int style);
      case (style)
         0: return $urandom;
         1: return $signed($urandom_range(0, 6)) - 3;
         default: begin
            case ($urandom_range(0, 6))
               0: return 32'sh8000_0000;
               1: return 32'sh7FFF_FFFF;
               2: return 32'sh0000_0000;
               3: return -32'sd1;
               4: return 32'sh8000_0001;
               5: return 32'sh7FFF_FFFE;
               default: return $urandom;
            endcase
         end
      endcase
   endfunction

   // Request driver: bursts with random gaps, holds a request until it is taken,
   // and waits for all responses before a request marked to drain first.
   always @(posedge clock) begin
      sort_request_type next_req;
      if (reset) begin
         req_ch.valid <= 1'b0;
         burst_left = $urandom_range(1, 12);
         gap_left = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_sorted_set(req_ch.value, req_ch.is_last);
            requests_accepted++;
         end
         if (!(req_ch.valid && !req_ch.ready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (pending_requests.size() == 0 ||
                         (pending_requests[0].drain_first && expected_sorted.size() != 0)) begin
               req_ch.valid <= 1'b0;
            end else begin
               next_req = pending_requests.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.value <= next_req.value;
               req_ch.is_last <= next_req.is_last;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 12);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   // Response ready: a randomly redrawn stall mode, plus one long hold-off once
   // at least eight sets have closed, started while a request is waiting at the
   // input, so the sender backs up against a busy block.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         ready_cycle = 0;
         stall_mode = 0;
      end else begin
         ready_cycle++;
         if (ready_cycle % 50 == 0) stall_mode = $urandom_range(0, 3);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!long_hold_done && rsp_ch.valid && req_ch.valid && !req_ch.ready &&
                      sets_closed >= 8) begin
            long_hold_done = 1'b1;
            hold_left = LongHoldCycles;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (stall_mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= $urandom_range(0, 1);
               2: rsp_ch.ready <= (ready_cycle % 4 == 0);
               default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   // Response monitor: compare each accepted response with the oldest prediction.
   always @(posedge clock) begin
      sorted_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_sorted.size() == 0) begin
            $error("unexpected response: sorted_value %0d", rsp_ch.sorted_value);
            error_count++;
         end else begin
            want = expected_sorted.pop_front();
            responses_checked++;
            if (rsp_ch.sorted_value !== want.sorted_value) begin
               $error("sorted_value: expected %0d, got %0d", want.sorted_value,
                      rsp_ch.sorted_value);
               error_count++;
            end
            if (rsp_ch.is_final !== want.is_final) begin
               $error("is_final: expected %0b, got %0b", want.is_final, rsp_ch.is_final);
               error_count++;
            end
            if (rsp_ch.overflow !== want.overflow) begin
               $error("overflow: expected %0b, got %0b", want.overflow, rsp_ch.overflow);
               error_count++;
            end
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      int random_requests;
      int set_size;
      int style;
      int pick;
      bit drain;
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.value = '0;
      req_ch.is_last = 1'b0;
      rsp_ch.ready = 1'b0;
      held_count = 0;
      held_dropped = 1'b0;
      requests_accepted = 0;
      sets_closed = 0;
      sets_overflowed = 0;
      responses_checked = 0;
      error_count = 0;
      hold_left = 0;
      long_hold_done = 1'b0;

      // A set of one element, which skips the sort.
      queue_request(32'shA5A5_A5A5, 1'b1, 1'b0);
      // Field extremes with a duplicate.
      queue_request(32'sh7FFF_FFFF, 1'b0, 1'b0);
      queue_request(32'sh8000_0000, 1'b0, 1'b0);
      queue_request(-32'sd1, 1'b0, 1'b0);
      queue_request(32'sd0, 1'b0, 1'b0);
      queue_request(32'sd1, 1'b0, 1'b0);
      queue_request(-32'sd1, 1'b1, 1'b0);
      // A full store whose closing request is dropped.
      for (int k = 1; k <= Capacity; k++) begin
         queue_request((k % 2) ? -k * 1000 : k * 1000, 1'b0, 1'b0);
      end
      queue_request(32'sh7FFF_FFFF, 1'b1, 1'b0);

      // Random sets: mostly in range, some exactly full, some overflowing.
      random_requests = 0;
      drain = 1'b1;
      while (random_requests < RandomRequestTarget) begin
         pick = $urandom_range(0, 9);
         if (pick < 2) set_size = $urandom_range(1, 3);
         else if (pick < 7) set_size = $urandom_range(1, Capacity);
         else if (pick == 7) set_size = Capacity;
         else set_size = $urandom_range(Capacity + 1, Capacity + 4);
         style = $urandom_range(0, 2);
         for (int k = 0; k < set_size; k++) begin
            queue_request(random_element(style), k == set_size - 1, drain && k == 0);
         end
         random_requests += set_size;
         drain = ($urandom_range(0, 5) == 0);
      end
      requests_total = pending_requests.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (requests_accepted < requests_total) @(posedge clock);
      while (expected_sorted.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d requests in %0d sets, %0d of them overflowing; checked %0d responses.",
               requests_accepted, sets_closed, sets_overflowed, responses_checked);
      if (error_count == 0) begin
         $display("integer_set_sorter verification clean");
      end else begin
         $display("integer_set_sorter verification failed");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2000000;
      $display("integer_set_sorter verification failed");
      $finish;
   end

endmodule
